// ===== sv/spg_pkg.sv =====
// Shared types and constants for the stepper pulse generator.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none

package spg_pkg;

   // Width of the tracked axis coordinate (8 to 32 bits).
   localparam int COUNTER_BITS = 16;
   // Width at which position and limits are compared.
   localparam int CMP_BITS = (COUNTER_BITS > 16) ? COUNTER_BITS : 16;
   // Fixed widths of the interface fields.
   localparam int FIELD_BITS = 16;
   localparam int CSR_INDEX_BITS = 2;

   // Register reset values.
   localparam logic [FIELD_BITS-1:0] DIVIDE_RESET = 16'd1;
   localparam logic [FIELD_BITS-1:0] UPPER_RESET = 16'hFFFF;
   localparam logic [FIELD_BITS-1:0] LOWER_RESET = 16'd100;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_DIVIDE_RATIO = 2'd0,
      CSR_UPPER_LIMIT = 2'd1,
      CSR_LOWER_LIMIT = 2'd2,
      CSR_HOMING_MODE = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      OP_TICK = 2'd0,
      OP_LOAD_MOVE = 2'd1,
      OP_SET_POSITION = 2'd2
   } opcode_type;

   typedef struct packed {
      logic [FIELD_BITS-1:0] divide_ratio;
      logic [FIELD_BITS-1:0] upper_limit;
      logic [FIELD_BITS-1:0] lower_limit;
      logic homing_mode;
   } cfg_type;

   typedef struct packed {
      logic [1:0] opcode;
      logic [FIELD_BITS-1:0] pulse_count;
      logic direction;
      logic [FIELD_BITS-1:0] position_value;
   } item_type;

   typedef struct packed {
      logic step_out;
      logic [FIELD_BITS-1:0] position;
      logic [FIELD_BITS-1:0] remaining;
      logic running;
      logic blocked;
   } result_type;

endpackage

`default_nettype wire

// ===== sv/spg_cfg_regs.sv =====
// Configuration registers of the stepper pulse generator.
// Depends on spg_pkg for the register indexes, reset values and cfg_type.
`default_nettype none

module spg_cfg_regs (
   input wire logic clock,
   input wire logic reset,
   input wire logic csr_write_enable,
   input wire logic [spg_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input wire logic [spg_pkg::FIELD_BITS-1:0] csr_wdata,
   output spg_pkg::cfg_type cfg
);

   spg_pkg::cfg_type cfg_ff;
   spg_pkg::cfg_type cfg_in;

   // Decode a write into the addressed register.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (spg_pkg::csr_index_type'(csr_index))
            spg_pkg::CSR_DIVIDE_RATIO: cfg_in.divide_ratio = csr_wdata;
            spg_pkg::CSR_UPPER_LIMIT: cfg_in.upper_limit = csr_wdata;
            spg_pkg::CSR_LOWER_LIMIT: cfg_in.lower_limit = csr_wdata;
            spg_pkg::CSR_HOMING_MODE: cfg_in.homing_mode = csr_wdata[0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.divide_ratio <= spg_pkg::DIVIDE_RESET;
         cfg_ff.upper_limit <= spg_pkg::UPPER_RESET;
         cfg_ff.lower_limit <= spg_pkg::LOWER_RESET;
         cfg_ff.homing_mode <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== sv/spg_in_stage.sv =====
// Input register of the stepper pulse generator: holds one accepted item.
// Depends on spg_pkg for item_type.
`default_nettype none

module spg_in_stage (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_ready,
   input wire spg_pkg::item_type req_item,
   input wire logic take,
   output logic item_valid,
   output spg_pkg::item_type item
);

   logic valid_ff;
   logic valid_in;
   spg_pkg::item_type item_ff;
   spg_pkg::item_type item_in;
   logic req_fire;

   // The register takes a new transfer when empty or when its item moves on.
   assign req_ready = !valid_ff || take;
   assign req_fire = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      item_in = item_ff;
      if (req_fire) begin
         valid_in = 1'b1;
         item_in = req_item;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item = item_ff;

endmodule

`default_nettype wire

// ===== sv/spg_axis_core.sv =====
// Axis state and single-pass update logic for one item per cycle while advance is set.
// Depends on spg_pkg for cfg_type, item_type, result_type and opcodes.
`default_nettype none

module spg_axis_core (
   input wire logic clock,
   input wire logic reset,
   input wire spg_pkg::cfg_type cfg,
   input wire logic advance,
   input wire spg_pkg::item_type item,
   output spg_pkg::result_type result
);

   logic [spg_pkg::FIELD_BITS-1:0] prescale_ff, prescale_in;
   logic phase_ff, phase_in;
   logic [spg_pkg::FIELD_BITS-1:0] steps_ff, steps_in;
   logic [spg_pkg::COUNTER_BITS-1:0] pos_ff, pos_in;
   logic dir_ff, dir_in;
   logic active_ff, active_in;
   logic blocked;
   logic allow;
   logic [spg_pkg::FIELD_BITS-1:0] prescale_next;
   logic [spg_pkg::CMP_BITS-1:0] pos_cmp;

   // Soft-limit check on the current position and direction.
   assign pos_cmp = spg_pkg::CMP_BITS'(pos_ff);
   always_comb begin
      if (cfg.homing_mode) begin
         allow = 1'b1;
      end else if (!dir_ff) begin
         allow = pos_cmp <= spg_pkg::CMP_BITS'(cfg.upper_limit);
      end else begin
         allow = pos_cmp >= spg_pkg::CMP_BITS'(cfg.lower_limit);
      end
   end

   assign prescale_next = prescale_ff + 1'b1;

   // Next state for the item in the input register.
   always_comb begin
      prescale_in = prescale_ff;
      phase_in = phase_ff;
      steps_in = steps_ff;
      pos_in = pos_ff;
      dir_in = dir_ff;
      active_in = active_ff;
      blocked = 1'b0;
      case (spg_pkg::opcode_type'(item.opcode))
         spg_pkg::OP_TICK: begin
            if (steps_ff == '0) begin
               active_in = 1'b0;
            end else if (!allow) begin
               blocked = 1'b1;
            end else if (prescale_next == cfg.divide_ratio) begin
               prescale_in = '0;
               phase_in = !phase_ff;
               // The falling half completes a step.
               if (phase_ff) begin
                  steps_in = steps_ff - 1'b1;
                  pos_in = dir_ff ? pos_ff - 1'b1 : pos_ff + 1'b1;
               end
            end else begin
               prescale_in = prescale_next;
            end
         end
         spg_pkg::OP_LOAD_MOVE: begin
            steps_in = item.pulse_count;
            dir_in = item.direction;
            prescale_in = '0;
            phase_in = 1'b0;
            active_in = 1'b1;
         end
         spg_pkg::OP_SET_POSITION: begin
            pos_in = spg_pkg::COUNTER_BITS'(item.position_value);
         end
         default: begin
            blocked = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prescale_ff <= '0;
         phase_ff <= 1'b0;
         steps_ff <= '0;
         pos_ff <= '0;
         dir_ff <= 1'b0;
         active_ff <= 1'b0;
      end else if (advance) begin
         prescale_ff <= prescale_in;
         phase_ff <= phase_in;
         steps_ff <= steps_in;
         pos_ff <= pos_in;
         dir_ff <= dir_in;
         active_ff <= active_in;
      end
   end

   // Result reports the state after the item.
   assign result.step_out = phase_in;
   assign result.position = spg_pkg::FIELD_BITS'(pos_in);
   assign result.remaining = steps_in;
   assign result.running = active_in;
   assign result.blocked = blocked;

endmodule

`default_nettype wire

// ===== sv/spg_out_stage.sv =====
// Result register of the stepper pulse generator.
// Depends on spg_pkg for result_type.
`default_nettype none

module spg_out_stage (
   input wire logic clock,
   input wire logic reset,
   input wire logic load,
   input wire spg_pkg::result_type result_in,
   output logic can_load,
   output logic rsp_valid,
   input wire logic rsp_ready,
   output spg_pkg::result_type result
);

   logic valid_ff;
   logic valid_in;
   spg_pkg::result_type result_ff;

   // Room for a new result when empty or when the waiting one is taken.
   assign can_load = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign result = result_ff;

endmodule

`default_nettype wire

// ===== sv/stepper_pulse_generator_unit.sv =====
// Single-axis stepper pulse generator. Each transfer is a timer tick, the
// load of a move or a new position, and gives exactly one result with the
// step level, position, remaining steps, running flag and a soft-limit
// blocked flag. One item is taken every clock cycle unless a result waits
// untaken; an item is held in the input register and its result is then
// written into the result register. The axis state is updated in a single
// pass from the input register, which sets that rate. Configuration
// registers may be written only while no item is in flight.
// Depends on spg_pkg, spg_cfg_regs, spg_in_stage, spg_axis_core, spg_out_stage.
`default_nettype none

module stepper_pulse_generator_unit (
   input wire logic clock,
   input wire logic reset,
   input wire logic csr_write_enable,
   input wire logic [spg_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input wire logic [spg_pkg::FIELD_BITS-1:0] csr_wdata,
   input wire logic req_valid,
   output logic req_ready,
   input wire logic [1:0] req_opcode,
   input wire logic [spg_pkg::FIELD_BITS-1:0] req_pulse_count,
   input wire logic req_direction,
   input wire logic [spg_pkg::FIELD_BITS-1:0] req_position_value,
   output logic rsp_valid,
   input wire logic rsp_ready,
   output logic rsp_step_out,
   output logic [spg_pkg::FIELD_BITS-1:0] rsp_position,
   output logic [spg_pkg::FIELD_BITS-1:0] rsp_remaining,
   output logic rsp_running,
   output logic rsp_blocked
);

   spg_pkg::cfg_type cfg;
   spg_pkg::item_type req_item;
   spg_pkg::item_type item;
   spg_pkg::result_type core_result;
   spg_pkg::result_type rsp_result;
   logic item_valid;
   logic can_load;
   logic take;

   assign req_item.opcode = req_opcode;
   assign req_item.pulse_count = req_pulse_count;
   assign req_item.direction = req_direction;
   assign req_item.position_value = req_position_value;

   // An item moves on when the result register has room for its result.
   assign take = item_valid && can_load;

   spg_cfg_regs u_cfg (
      .clock(clock),
      .reset(reset),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .cfg(cfg)
   );

   spg_in_stage u_in (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_item(req_item),
      .take(take),
      .item_valid(item_valid),
      .item(item)
   );

   spg_axis_core u_core (
      .clock(clock),
      .reset(reset),
      .cfg(cfg),
      .advance(take),
      .item(item),
      .result(core_result)
   );

   spg_out_stage u_out (
      .clock(clock),
      .reset(reset),
      .load(take),
      .result_in(core_result),
      .can_load(can_load),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .result(rsp_result)
   );

   assign rsp_step_out = rsp_result.step_out;
   assign rsp_position = rsp_result.position;
   assign rsp_remaining = rsp_result.remaining;
   assign rsp_running = rsp_result.running;
   assign rsp_blocked = rsp_result.blocked;

endmodule

`default_nettype wire

// ===== sv/spg_checker.sv =====
// Port-level checks for the stepper pulse generator, bound to the top level.
// Depends on spg_pkg and stepper_pulse_generator_unit.
`default_nettype none

module spg_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic rsp_step_out,
   input wire logic [spg_pkg::FIELD_BITS-1:0] rsp_position,
   input wire logic [spg_pkg::FIELD_BITS-1:0] rsp_remaining,
   input wire logic rsp_running,
   input wire logic rsp_blocked
);

   // No result is offered straight after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered after reset");

   // Input is refused only while a result waits without being taken.
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("input refused without a stalled result");

   // Steps left always means a move is running.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_remaining != '0)) |-> rsp_running)
      else $error("steps left while not running");

   // A blocked tick only happens with steps left.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_blocked) |-> (rsp_remaining != '0))
      else $error("blocked without steps left");

   // A stalled result holds its value.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_position)
         && $stable(rsp_remaining) && $stable(rsp_step_out)))
      else $error("stalled result changed");

endmodule

bind stepper_pulse_generator_unit spg_checker u_spg_checker (
   .clock(clock),
   .reset(reset),
   .req_ready(req_ready),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_step_out(rsp_step_out),
   .rsp_position(rsp_position),
   .rsp_remaining(rsp_remaining),
   .rsp_running(rsp_running),
   .rsp_blocked(rsp_blocked)
);

`default_nettype wire

// ===== verif/tb_stepper_pulse_generator_unit.sv =====
// Self-checking testbench for stepper_pulse_generator_unit: directed and random
// tick, move and position traffic, checked against a behavioural axis model.
// Depends on spg_pkg and the unit's RTL only.
`timescale 1ns / 1ps

module tb_stepper_pulse_generator_unit;

   // Opcode three has no meaning and must leave the axis untouched.
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int HOLD_CYCLES = 300;
   localparam int MAX_REPORTS = 40;
   localparam int DRAIN_LIMIT = 100000;

   logic clock = 1'b0;
   logic reset;
   logic csr_write_enable;
   logic [spg_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [spg_pkg::FIELD_BITS-1:0] csr_wdata;
   logic req_valid;
   logic req_ready;
   logic [1:0] req_opcode;
   logic [spg_pkg::FIELD_BITS-1:0] req_pulse_count;
   logic req_direction;
   logic [spg_pkg::FIELD_BITS-1:0] req_position_value;
   logic rsp_valid;
   logic rsp_ready;
   logic rsp_step_out;
   logic [spg_pkg::FIELD_BITS-1:0] rsp_position;
   logic [spg_pkg::FIELD_BITS-1:0] rsp_remaining;
   logic rsp_running;
   logic rsp_blocked;

   stepper_pulse_generator_unit uut (
      .clock(clock),
      .reset(reset),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_opcode(req_opcode),
      .req_pulse_count(req_pulse_count),
      .req_direction(req_direction),
      .req_position_value(req_position_value),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_step_out(rsp_step_out),
      .rsp_position(rsp_position),
      .rsp_remaining(rsp_remaining),
      .rsp_running(rsp_running),
      .rsp_blocked(rsp_blocked)
   );

   // Clock generation, 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Copy of the configuration as the block should hold it.
   logic [spg_pkg::FIELD_BITS-1:0] ratio_setting;
   logic [spg_pkg::FIELD_BITS-1:0] upper_bound;
   logic [spg_pkg::FIELD_BITS-1:0] lower_bound;
   logic homing_on;

   // Copy of the axis state.
   logic [15:0] prescaler;
   logic step_level;
   logic [15:0] steps_pending;
   logic [spg_pkg::COUNTER_BITS-1:0] axis_pos;
   logic move_reverse;
   logic move_active;

   spg_pkg::result_type axis_results_due[$];
   int unsigned error_count = 0;

   // Traffic shaping controls.
   bit req_idle_on = 1'b1;
   bit rsp_idle_on = 1'b1;
   bit hold_request = 1'b0;

   // Advance the axis model by one item and return the result it should give.
   function automatic spg_pkg::result_type predict_axis(input spg_pkg::item_type it);
      spg_pkg::result_type r;
      logic allowed;
      r.blocked = 1'b0;
      case (it.opcode)
         spg_pkg::OP_TICK: begin
            if (steps_pending != 16'd0) begin
               if (homing_on)
                  allowed = 1'b1;
               else if (!move_reverse)
                  allowed = (axis_pos <= upper_bound);
               else
                  allowed = (axis_pos >= lower_bound);
               if (allowed) begin
                  prescaler = prescaler + 16'd1;
                  if (prescaler == ratio_setting) begin
                     prescaler = 16'd0;
                     if (!step_level) begin
                        step_level = 1'b1;
                     end else begin
                        step_level = 1'b0;
                        steps_pending = steps_pending - 16'd1;
                        if (!move_reverse)
                           axis_pos = axis_pos + 1'b1;
                        else
                           axis_pos = axis_pos - 1'b1;
                     end
                  end
               end else begin
                  r.blocked = 1'b1;
               end
            end else begin
               move_active = 1'b0;
            end
         end
         spg_pkg::OP_LOAD_MOVE: begin
            steps_pending = it.pulse_count;
            move_reverse = it.direction;
            prescaler = 16'd0;
            step_level = 1'b0;
            move_active = 1'b1;
         end
         spg_pkg::OP_SET_POSITION: begin
            axis_pos = it.position_value;
         end
         default: ;
      endcase
      r.step_out = step_level;
      r.position = axis_pos;
      r.remaining = steps_pending;
      r.running = move_active;
      return r;
   endfunction

   function automatic spg_pkg::item_type make_item(input logic [1:0] op,
                                                   input logic [15:0] count,
                                                   input logic dir, input logic [15:0] pos);
      spg_pkg::item_type it;
      it.opcode = op;
      it.pulse_count = count;
      it.direction = dir;
      it.position_value = pos;
      return it;
   endfunction

   // A position close to one of the soft limits or to the top of the range, or anywhere at all.
   function automatic logic [15:0] position_near_limit();
      logic [15:0] offset;
      offset = 16'($urandom_range(0, 6)) - 16'd3;
      case ($urandom_range(0, 3))
         0: return lower_bound + offset;
         1: return upper_bound + offset;
         2: return 16'hFFFF - 16'($urandom_range(0, 2));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic spg_pkg::item_type random_item();
      int unsigned pick;
      spg_pkg::item_type it;
      pick = $urandom_range(0, 99);
      it = make_item(spg_pkg::OP_TICK, 16'($urandom), 1'($urandom), 16'($urandom));
      if (pick >= 94) begin
         it.opcode = OP_UNUSED;
      end else if (pick >= 80) begin
         it.opcode = spg_pkg::OP_SET_POSITION;
         if ($urandom_range(0, 2) != 0)
            it.position_value = position_near_limit();
      end else if (pick >= 66) begin
         it.opcode = spg_pkg::OP_LOAD_MOVE;
         if ($urandom_range(0, 3) != 0)
            it.pulse_count = 16'($urandom_range(0, 6));
      end
      return it;
   endfunction

   // Offer one item and wait for its transfer; the model is stepped at that edge.
   task automatic send_item(input spg_pkg::item_type it);
      int unsigned gap;
      if (req_idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 11);
         repeat (gap) begin
            @(negedge clock);
            req_valid <= 1'b0;
         end
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_opcode <= it.opcode;
      req_pulse_count <= it.pulse_count;
      req_direction <= it.direction;
      req_position_value <= it.position_value;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      axis_results_due.push_back(predict_axis(it));
   endtask

   task automatic issue(input logic [1:0] op, input logic [15:0] count, input logic dir,
                        input logic [15:0] pos);
      send_item(make_item(op, count, dir, pos));
   endtask

   task automatic send_tick();
      issue(spg_pkg::OP_TICK, 16'($urandom), 1'($urandom), 16'($urandom));
   endtask

   // Stop offering and wait until every result has come back.
   task automatic settle_block();
      @(negedge clock);
      req_valid <= 1'b0;
      while (axis_results_due.size() != 0)
         @(posedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_register(input spg_pkg::csr_index_type idx,
                                 input logic [15:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         spg_pkg::CSR_DIVIDE_RATIO: ratio_setting = value;
         spg_pkg::CSR_UPPER_LIMIT: upper_bound = value;
         spg_pkg::CSR_LOWER_LIMIT: lower_bound = value;
         spg_pkg::CSR_HOMING_MODE: homing_on = value[0];
         default: ;
      endcase
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic configure(input logic [15:0] ratio, input logic [15:0] upper,
                            input logic [15:0] lower, input logic homing);
      settle_block();
      write_register(spg_pkg::CSR_DIVIDE_RATIO, ratio);
      write_register(spg_pkg::CSR_UPPER_LIMIT, upper);
      write_register(spg_pkg::CSR_LOWER_LIMIT, lower);
      write_register(spg_pkg::CSR_HOMING_MODE, {15'd0, homing});
   endtask

   // Mostly moves (optional position, load, then ticks toward the end of the move, capped),
   // with random items mixed in as noise.
   task automatic random_moves(input int unsigned item_target);
      int unsigned sent;
      int unsigned ticks;
      spg_pkg::item_type it;
      sent = 0;
      while (sent < item_target) begin
         if ($urandom_range(0, 9) < 7) begin
            if ($urandom_range(0, 1) == 0) begin
               issue(spg_pkg::OP_SET_POSITION, 16'($urandom), 1'($urandom),
                     position_near_limit());
               sent++;
            end
            it = make_item(spg_pkg::OP_LOAD_MOVE, 16'($urandom_range(0, 5)), 1'($urandom),
                           16'($urandom));
            send_item(it);
            sent++;
            ticks = 2 * it.pulse_count * ratio_setting + $urandom_range(0, 3);
            if (ticks > 40)
               ticks = 40;
            repeat (ticks) begin
               if ($urandom_range(0, 19) == 0) begin
                  it = random_item();
                  send_item(it);
                  if (it.opcode != OP_UNUSED)
                     sent++;
               end else begin
                  send_tick();
                  sent++;
               end
            end
         end else begin
            it = random_item();
            send_item(it);
            if (it.opcode != OP_UNUSED)
               sent++;
         end
      end
   endtask

   // Idle ticks, the unused opcode, a move across the top of the position range,
   // a move with no pulses and a backward move held by the lower limit.
   task automatic test_move_basics();
      send_tick();
      issue(OP_UNUSED, 16'hFFFF, 1'b1, 16'hFFFF);
      issue(spg_pkg::OP_SET_POSITION, 16'h0000, 1'b0, 16'hFFFF);
      issue(spg_pkg::OP_LOAD_MOVE, 16'd2, 1'b0, 16'h0000);
      repeat (5) send_tick();
      issue(spg_pkg::OP_LOAD_MOVE, 16'd0, 1'b1, 16'hFFFF);
      send_tick();
      // Backward from zero is below the reset lower limit and must be held.
      issue(spg_pkg::OP_SET_POSITION, 16'hFFFF, 1'b1, 16'h0000);
      issue(spg_pkg::OP_LOAD_MOVE, 16'd3, 1'b1, 16'h0000);
      send_tick();
   endtask

   // Homing bypass with the limits at opposite extremes, then both limits
   // enforced again.
   task automatic test_limits_and_homing();
      configure(16'd1, 16'h0000, 16'hFFFF, 1'b1);
      send_tick();
      send_tick();
      configure(16'd1, 16'h0000, 16'hFFFF, 1'b0);
      issue(spg_pkg::OP_LOAD_MOVE, 16'hFFFF, 1'b0, 16'h0000);
      send_tick();
      issue(spg_pkg::OP_SET_POSITION, 16'h0000, 1'b0, 16'h0000);
      repeat (3) send_tick();
      issue(spg_pkg::OP_LOAD_MOVE, 16'd1, 1'b1, 16'h0000);
      send_tick();
   endtask

   // Ratio lowered below the running count, then ratio zero: in both cases the
   // prescaler counts on past the value without a match, so the step level holds.
   task automatic test_prescaler_wrap();
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      configure(16'd3, 16'hFFFF, 16'h0000, 1'b0);
      issue(spg_pkg::OP_SET_POSITION, 16'h0000, 1'b0, 16'd1000);
      issue(spg_pkg::OP_LOAD_MOVE, 16'd2, 1'b0, 16'h0000);
      send_tick();
      send_tick();
      settle_block();
      write_register(spg_pkg::CSR_DIVIDE_RATIO, 16'd1);
      repeat (40) send_tick();
      settle_block();
      write_register(spg_pkg::CSR_DIVIDE_RATIO, 16'd0);
      repeat (40) send_tick();
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   // The receiver holds off for a long stretch while items keep coming, so
   // the block fills and stops taking transfers.
   task automatic test_backpressure();
      configure(16'd1, 16'hFFFF, 16'd0, 1'b0);
      hold_request = 1'b1;
      req_idle_on = 1'b0;
      random_moves(40);
      req_idle_on = 1'b1;
   endtask

   // Random traffic over several configurations, the extremes among them.
   task automatic test_random_traffic();
      int unsigned phase;
      for (phase = 0; phase < 8; phase++) begin
         case (phase)
            0: configure(16'd1, 16'hFFFF, 16'h0000, 1'b0);
            1: configure(16'hFFFF, 16'h0000, 16'hFFFF, 1'b1);
            2: configure(16'd0, 16'($urandom), 16'($urandom), 1'b0);
            default: configure(16'($urandom_range(1, 3)), 16'($urandom), 16'($urandom),
                               1'($urandom));
         endcase
         random_moves(phase < 2 ? 40 : 80);
      end
   endtask

   // Final stretch with both sides always ready.
   task automatic test_steady_stream();
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      configure(16'd1, 16'($urandom_range(1000, 65535)), 16'($urandom_range(0, 999)),
                1'b0);
      random_moves(80);
   endtask

   // Receiver: random stall bursts, plus the one long hold-off on request.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            hold_request = 1'b0;
         end else if (rsp_idle_on && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(0, 10)) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic report_field(input string field_name, input logic [15:0] expected_value,
                               input logic [15:0] actual_value);
      if (expected_value !== actual_value) begin
         error_count++;
         if (error_count <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field_name,
                     expected_value, actual_value);
      end
   endtask

   // Result checker: each transfer is compared with the oldest expectation.
   always @(posedge clock) begin
      spg_pkg::result_type due;
      if (!reset && rsp_valid && rsp_ready) begin
         if (axis_results_due.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("%0t: result with none expected, expected nothing, actual pos %0d",
                        $time, rsp_position);
         end else begin
            due = axis_results_due.pop_front();
            report_field("step_out", 16'(due.step_out), 16'(rsp_step_out));
            report_field("position", due.position, rsp_position);
            report_field("remaining", due.remaining, rsp_remaining);
            report_field("running", 16'(due.running), 16'(rsp_running));
            report_field("blocked", 16'(due.blocked), 16'(rsp_blocked));
         end
      end
   end

   // Watchdog.
   initial begin
      #20ms;
      $display("tb_stepper_pulse_generator_unit: errors");
      $finish;
   end

   // Main sequence.
   initial begin
      int unsigned waited;
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = spg_pkg::CSR_DIVIDE_RATIO;
      csr_wdata = '0;
      req_valid = 1'b0;
      req_opcode = spg_pkg::OP_TICK;
      req_pulse_count = '0;
      req_direction = 1'b0;
      req_position_value = '0;
      ratio_setting = spg_pkg::DIVIDE_RESET;
      upper_bound = spg_pkg::UPPER_RESET;
      lower_bound = spg_pkg::LOWER_RESET;
      homing_on = 1'b0;
      prescaler = '0;
      step_level = 1'b0;
      steps_pending = '0;
      axis_pos = '0;
      move_reverse = 1'b0;
      move_active = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_move_basics();
      test_limits_and_homing();
      test_prescaler_wrap();
      test_backpressure();
      test_random_traffic();
      test_steady_stream();

      @(negedge clock);
      req_valid <= 1'b0;
      waited = 0;
      while (axis_results_due.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (10) @(posedge clock);
      if (axis_results_due.size() != 0) begin
         error_count++;
         $display("%0t: results outstanding, expected 0, actual %0d", $time,
                  axis_results_due.size());
      end
      if (error_count == 0)
         $display("tb_stepper_pulse_generator_unit: clean");
      else
         $display("tb_stepper_pulse_generator_unit: errors");
      $finish;
   end

endmodule

// ===== stepper_pulse_generator_unit.f =====
sv/spg_pkg.sv
sv/spg_cfg_regs.sv
sv/spg_in_stage.sv
sv/spg_axis_core.sv
sv/spg_out_stage.sv
sv/stepper_pulse_generator_unit.sv
sv/spg_checker.sv
verif/tb_stepper_pulse_generator_unit.sv
